@@ rtl/core/rfe_pkg.sv @@
package rfe_pkg;

   localparam int FRAME_BYTES = 7;
   localparam int BYTE_IDX_W  = $clog2(FRAME_BYTES);
   localparam int PAY_BYTES   = 2 * FRAME_BYTES;
   localparam int PAY_IDX_W   = $clog2(PAY_BYTES);
   localparam logic [PAY_IDX_W-1:0] PAY_LAST = PAY_IDX_W'(PAY_BYTES - 1);

   localparam logic [7:0] KEY_RESET     = 8'ha0;
   localparam logic [7:0] PREAMBLE_BYTE = 8'hf0;
   localparam logic [7:0] SYNC_BYTE     = 8'hfe;
   localparam logic [3:0] NIBBLE_MASK   = 4'hf;
   localparam logic [5:0] MAX_PREAMBLE  = 6'd49;

   localparam logic [1:0] KIND_PREAMBLE = 2'd0;
   localparam logic [1:0] KIND_SYNC     = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD  = 2'd2;

   typedef logic [FRAME_BYTES-1:0][7:0] frame_type;

   typedef struct packed {
      frame_type  frame;
      logic [5:0] preamble;
   } frame_entry_type;

   typedef struct packed {
      logic            valid;
      frame_entry_type entry;
   } entry_xfer_type;

   function automatic logic [7:0] manchester_nibble(input logic [3:0] nib);
      logic [7:0] r;
      r = 8'h00;
      for (int b = 0; b < 4; b++) begin
         r[2*b +: 2] = nib[b] ? 2'b01 : 2'b10;
      end
      return r;
   endfunction

   function automatic logic [7:0] frame_byte(input frame_type fr,
                                             input logic [BYTE_IDX_W-1:0] idx);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         if (idx == BYTE_IDX_W'(i)) begin
            r = fr[i];
         end
      end
      return r;
   endfunction

endpackage

@@ rtl/core/rfe_front.sv @@
module rfe_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [7:0]              csr_write_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [3:0]              req_command_code,
   input  logic [15:0]             req_rolling_code,
   input  logic [23:0]             req_remote_address,
   input  logic [5:0]              req_preamble_count,
   output rfe_pkg::entry_xfer_type q_push,
   input  logic                    q_stall
);
   import rfe_pkg::*;

   logic [7:0]      key_ff;
   logic            valid_ff, valid_in;
   frame_entry_type entry_ff, entry_in;
   logic            accept;
   logic [3:0]      cks;
   frame_type       fr;

   assign req_stall = valid_ff && q_stall;
   assign accept    = req_valid && !req_stall;

   // build the frame: checksum over all nibbles, then chain each byte onto the previous
   always_comb begin
      fr[0] = key_ff;
      fr[1] = {req_command_code, 4'h0};
      fr[2] = req_rolling_code[15:8];
      fr[3] = req_rolling_code[7:0];
      fr[4] = req_remote_address[23:16];
      fr[5] = req_remote_address[15:8];
      fr[6] = req_remote_address[7:0];
      cks = 4'h0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         cks = cks ^ (fr[i][3:0] & NIBBLE_MASK) ^ (fr[i][7:4] & NIBBLE_MASK);
      end
      fr[1][3:0] = cks;
      for (int i = 1; i < FRAME_BYTES; i++) begin
         fr[i] = fr[i] ^ fr[i-1];
      end
      entry_in.frame    = fr;
      entry_in.preamble = (req_preamble_count > MAX_PREAMBLE) ? MAX_PREAMBLE
                                                              : req_preamble_count;
   end

   assign valid_in = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= KEY_RESET;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (csr_write_enable) begin
            key_ff <= csr_write_data;
         end
      end
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

   assign q_push.valid = valid_ff;
   assign q_push.entry = entry_ff;

`ifndef SYNTHESIS
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      valid_ff && q_stall |=> valid_ff && $stable(entry_ff))
      else $error("front entry changed while the queue stalled");
`endif

endmodule

@@ rtl/core/rfe_queue.sv @@
module rfe_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  rfe_pkg::entry_xfer_type in_xfer,
   output logic                    in_stall,
   output rfe_pkg::entry_xfer_type out_xfer,
   input  logic                    out_stall
);
   import rfe_pkg::*;

   frame_entry_type mem_ff [2];
   logic            wr_ptr_ff, rd_ptr_ff;
   logic [1:0]      count_ff;
   logic            push, pop;

   assign in_stall = (count_ff == 2'd2);
   assign push     = in_xfer.valid && !in_stall;
   assign pop      = out_xfer.valid && !out_stall;

   assign out_xfer.valid = (count_ff != 2'd0);
   assign out_xfer.entry = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_xfer.entry;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count overflow");
`endif

endmodule

@@ rtl/core/rfe_back.sv @@
module rfe_back (
   input  logic                    clock,
   input  logic                    reset,
   input  rfe_pkg::entry_xfer_type q_pop,
   output logic                    q_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_line_byte,
   output logic [1:0]              rsp_byte_kind,
   output logic                    rsp_is_last
);
   import rfe_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_PRE, ST_SYNC, ST_PAY} state_type;

   state_type                state_ff, state_in;
   frame_entry_type          entry_ff;
   logic [5:0]               pre_cnt_ff, pre_cnt_in;
   logic [PAY_IDX_W-1:0]     pay_idx_ff, pay_idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               byte_ff, byte_in;
   logic [1:0]               kind_ff, kind_in;
   logic                     last_ff, last_in;
   logic                     advance, done, take;
   logic [7:0]               cur_byte;

   assign advance = (state_ff != ST_IDLE) && (!rsp_valid_ff || !rsp_stall);
   assign done    = advance && (state_ff == ST_PAY) && (pay_idx_ff == PAY_LAST);
   assign take    = q_pop.valid && ((state_ff == ST_IDLE) || done);
   assign q_stall = !take;

   assign cur_byte = frame_byte(entry_ff.frame, pay_idx_ff[PAY_IDX_W-1:1]);

   always_comb begin
      state_in     = state_ff;
      pre_cnt_in   = pre_cnt_ff;
      pay_idx_in   = pay_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      byte_in      = byte_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         last_in      = 1'b0;
         case (state_ff)
            ST_PRE: begin
               byte_in    = PREAMBLE_BYTE;
               kind_in    = KIND_PREAMBLE;
               pre_cnt_in = pre_cnt_ff - 6'd1;
               if (pre_cnt_ff == 6'd1) begin
                  state_in = ST_SYNC;
               end
            end
            ST_SYNC: begin
               byte_in    = SYNC_BYTE;
               kind_in    = KIND_SYNC;
               pay_idx_in = '0;
               state_in   = ST_PAY;
            end
            ST_PAY: begin
               byte_in    = pay_idx_ff[0] ? manchester_nibble(cur_byte[3:0])
                                          : manchester_nibble(cur_byte[7:4]);
               kind_in    = KIND_PAYLOAD;
               last_in    = (pay_idx_ff == PAY_LAST);
               pay_idx_in = pay_idx_ff + PAY_IDX_W'(1);
               if (pay_idx_ff == PAY_LAST) begin
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
      if (take) begin
         pre_cnt_in = q_pop.entry.preamble;
         state_in   = (q_pop.entry.preamble == 6'd0) ? ST_SYNC : ST_PRE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pre_cnt_ff   <= 6'd0;
         pay_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pre_cnt_ff   <= pre_cnt_in;
         pay_idx_ff   <= pay_idx_in;
      end
      byte_ff <= byte_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
      if (take) begin
         entry_ff <= q_pop.entry;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_line_byte = byte_ff;
   assign rsp_byte_kind = kind_ff;
   assign rsp_is_last   = last_ff;

`ifndef SYNTHESIS
   a_last_is_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> kind_ff == KIND_PAYLOAD)
      else $error("last flag on a non-payload byte");
   a_sync_after_preamble: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SYNC |-> pre_cnt_ff == 6'd0)
      else $error("sync reached with preamble bytes left");
   a_take_starts_frame: assert property (@(posedge clock) disable iff (reset)
      take |=> (state_ff == ST_PRE || state_ff == ST_SYNC))
      else $error("frame load did not start a preamble or sync");
`endif

endmodule

@@ rtl/core/rts_remote_frame_encoder_core.sv @@
// Rolling-code remote frame encoder.
//
// Request channel (req_*): one transaction carries a command, a rolling code,
// a remote address and a preamble count (clamped to 49). The key byte comes
// from the csr_* port, reset value 0xa0; write it only while the block idles.
// Result channel (rsp_*): one transaction per on-air byte: preamble_count
// bytes 0xf0, one sync byte 0xfe, then 14 Manchester bytes, the last flagged.
// The back-end sequencer emits one line byte per cycle while the receiver
// does not stall. The front end builds the frame in the cycle it accepts
// a request and parks it in a two-entry queue, so the next frame starts
// the cycle after the previous last byte. The first result passes through
// the front register, the queue, the sequencer state and the output register.
// Reset empties the front register, the queue and the sequencer and restores
// the key byte. When the receiver stalls, the output register holds its byte
// and the sequencer waits; the front keeps accepting until the queue fills.
module rts_remote_frame_encoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_command_code,
   input  logic [15:0] req_rolling_code,
   input  logic [23:0] req_remote_address,
   input  logic [5:0]  req_preamble_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_line_byte,
   output logic [1:0]  rsp_byte_kind,
   output logic        rsp_is_last
);
   import rfe_pkg::*;

   entry_xfer_type push_xfer, pop_xfer;
   logic           push_stall, pop_stall;

   // build frames from requests
   rfe_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command_code   (req_command_code),
      .req_rolling_code   (req_rolling_code),
      .req_remote_address (req_remote_address),
      .req_preamble_count (req_preamble_count),
      .q_push             (push_xfer),
      .q_stall            (push_stall)
   );

   // decouple front and back
   rfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_xfer   (push_xfer),
      .in_stall  (push_stall),
      .out_xfer  (pop_xfer),
      .out_stall (pop_stall)
   );

   // sequence preamble, sync and Manchester payload
   rfe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_pop         (pop_xfer),
      .q_stall       (pop_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_line_byte (rsp_line_byte),
      .rsp_byte_kind (rsp_byte_kind),
      .rsp_is_last   (rsp_is_last)
   );

endmodule
